// ===== sv/piecewise_linear_breakpoint_interp_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the breakpoint interpolation unit
// Shared property forms; each use sits on a line of its own.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_BREAKPOINT_INTERP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_BREAKPOINT_INTERP_UNIT_DEFINES_SVH

// same-cycle implication
`define PLIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("plic assertion failed");

// next-cycle implication
`define PLIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("plic assertion failed");

`endif

// ===== sv/plic_pkg.sv =====
// ----------------------------------------------------------------------------
// plic_pkg
// Widths, codes and shared types of the breakpoint interpolation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plic_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int POS_W      = 16;
  localparam int VAL_W      = 32;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int CELL_IDX_W = $clog2(MAX_POINTS);

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CH_W-1:0] {
    CH_PHI   = 2'd0,
    CH_PSI   = 2'd1,
    CH_KICK  = 2'd2,
    CH_WHACK = 2'd3
  } chan_e;

  typedef logic [NUM_CH-1:0][VAL_W-1:0] chval_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    chval_t           val;
  } wr_t;

  typedef struct packed {
    logic             vld;
    logic             found;
    logic [POS_W-1:0] res;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] after;
    logic [VAL_W-1:0] bv;
    logic [VAL_W-1:0] av;
  } tok_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             degen;
    logic             sat;
  } arith_res_t;

endpackage

`default_nettype wire

// ===== sv/plic_cell.sv =====
// ----------------------------------------------------------------------------
// plic_cell
// One breakpoint entry plus one segment check; passes the query word on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plic_cell
  import plic_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CELL_IDX_W-1:0] cell_idx_i,
  input  logic [CELL_IDX_W-1:0] last_idx_i,
  input  wr_t                   wr_i,
  input  logic [POS_W-1:0]      nxt_pos_i,
  input  chval_t                nxt_val_i,
  output logic [POS_W-1:0]      pos_o,
  output chval_t                val_o,
  input  tok_t                  tok_i,
  output tok_t                  tok_o
);

  logic [POS_W-1:0] pos_q;
  chval_t           val_q;
  tok_t             tok_q, tok_d;
  logic             in_seg, is_last, take;
  logic [VAL_W-1:0] own_v, nxt_v;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (CELL_IDX_W'(wr_i.idx) == cell_idx_i)) begin
      pos_q <= wr_i.pos;
      val_q <= wr_i.val;
    end
  end

  always_comb begin
    case (chan_e'(tok_i.ch))
      CH_PHI: begin
        own_v = val_q[0];
        nxt_v = nxt_val_i[0];
      end
      CH_PSI: begin
        own_v = val_q[1];
        nxt_v = nxt_val_i[1];
      end
      CH_KICK: begin
        own_v = val_q[2];
        nxt_v = nxt_val_i[2];
      end
      default: begin
        own_v = val_q[3];
        nxt_v = nxt_val_i[3];
      end
    endcase
  end

  assign in_seg  = ($signed(pos_q) <= $signed(tok_i.res)) &&
                   ($signed(tok_i.res) < $signed(nxt_pos_i));
  assign is_last = (cell_idx_i == last_idx_i);
  assign take    = !tok_i.found && (cell_idx_i <= last_idx_i) && (in_seg || is_last);

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.found  = 1'b1;
      tok_d.lo_pos = pos_q;
      tok_d.after  = nxt_pos_i;
      tok_d.bv     = own_v;
      tok_d.av     = nxt_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign pos_o = pos_q;
  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== sv/plic_arith.sv =====
// ----------------------------------------------------------------------------
// plic_arith
// Segment slope: split multiply, one-bit-per-cycle divide, add and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plic_arith
  import plic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  tok_t       seg_i,
  output logic       done_o,
  output arith_res_t res_o
);

  localparam int MAG_W  = 2 * POS_W + POS_W;
  localparam int HALF_W = VAL_W / 2;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int SUM_W  = MAG_W + 2;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  typedef enum logic [4:0] {
    A_IDLE   = 5'b00001,
    A_MUL_LO = 5'b00010,
    A_MUL_HI = 5'b00100,
    A_DIV    = 5'b01000,
    A_FIN    = 5'b10000
  } astate_e;

  astate_e           state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  logic [POS_W-1:0]  dres_mag_q, dpos_mag_q;
  logic [VAL_W-1:0]  diff_mag_q, bv_q;
  logic              neg_q, degen_q;
  logic [MAG_W-1:0]  prod_q, prod_d;
  logic [POS_W-1:0]  rem_q, rem_d;

  logic [POS_W:0]    dres, dres_n, dpos, dpos_n, trial_sh, trial_sub;
  logic [VAL_W:0]    diff, diff_n;
  logic [SUM_W-1:0]  sum, q_ext;
  logic              sat_hi, sat_lo;
  logic [POS_W+HALF_W-1:0] pp_lo, pp_hi;

  assign dres   = {seg_i.res[POS_W-1], seg_i.res} - {seg_i.lo_pos[POS_W-1], seg_i.lo_pos};
  assign dpos   = {seg_i.after[POS_W-1], seg_i.after} - {seg_i.lo_pos[POS_W-1], seg_i.lo_pos};
  assign diff   = {seg_i.av[VAL_W-1], seg_i.av} - {seg_i.bv[VAL_W-1], seg_i.bv};
  assign dres_n = -dres;
  assign dpos_n = -dpos;
  assign diff_n = -diff;

  assign pp_lo = {HALF_W'(0), dres_mag_q} * {POS_W'(0), diff_mag_q[HALF_W-1:0]};
  assign pp_hi = {HALF_W'(0), dres_mag_q} * {POS_W'(0), diff_mag_q[VAL_W-1:HALF_W]};

  assign trial_sh  = {rem_q, prod_q[MAG_W-1]};
  assign trial_sub = trial_sh - {1'b0, dpos_mag_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dres_mag_q <= dres[POS_W] ? dres_n[POS_W-1:0] : dres[POS_W-1:0];
      dpos_mag_q <= dpos[POS_W] ? dpos_n[POS_W-1:0] : dpos[POS_W-1:0];
      diff_mag_q <= diff[VAL_W] ? diff_n[VAL_W-1:0] : diff[VAL_W-1:0];
      neg_q      <= dres[POS_W] ^ dpos[POS_W] ^ diff[VAL_W];
      degen_q    <= (dpos == '0);
      bv_q       <= seg_i.bv;
    end
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = (dpos == '0) ? A_FIN : A_MUL_LO;
        end
      end
      A_MUL_LO: begin
        prod_d  = {POS_W'(0), pp_lo};
        state_d = A_MUL_HI;
      end
      A_MUL_HI: begin
        prod_d  = prod_q + {pp_hi, HALF_W'(0)};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = A_DIV;
      end
      A_DIV: begin
        if (!trial_sub[POS_W]) begin
          rem_d  = trial_sub[POS_W-1:0];
          prod_d = {prod_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d  = trial_sh[POS_W-1:0];
          prod_d = {prod_q[MAG_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) begin
          state_d = A_FIN;
        end
      end
      A_FIN: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign q_ext  = neg_q ? -{2'b00, prod_q} : {2'b00, prod_q};
  assign sum    = {{(SUM_W-VAL_W){bv_q[VAL_W-1]}}, bv_q} + q_ext;
  assign sat_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:VAL_W-1]);
  assign sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1]);

  always_comb begin
    res_o = '0;
    if (degen_q) begin
      res_o.degen = 1'b1;
    end else if (sat_hi) begin
      res_o.value = {1'b0, {(VAL_W-1){1'b1}}};
      res_o.sat   = 1'b1;
    end else if (sat_lo) begin
      res_o.value = {1'b1, {(VAL_W-1){1'b0}}};
      res_o.sat   = 1'b1;
    end else begin
      res_o.value = sum[VAL_W-1:0];
    end
  end

  assign done_o = (state_q == A_FIN);

endmodule

`default_nettype wire

// ===== sv/piecewise_linear_breakpoint_interp_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_breakpoint_interp_unit
// Breakpoint table in a row of cells, segment search, linear interpolation.
//
//   channel   dir   handshake                 payload
//   s_axis    in    s_axis_tvalid/tready      tdata entry/query, tuser op
//   m_axis    out   m_axis_tvalid/tready      tdata result, tuser flags
//   cfg       in    cfg_we_i                  cfg_wdata_i point_count
//
// A write word goes straight to the output stage. A query word walks along the
// cell row, then passes the split multiply and the 48-step divider, both skipped
// when the segment ends coincide. One word is in work at a time; the output
// register holds a result while the next word is taken. Reset clears control
// and the cell tokens; table entries hold nothing until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "piecewise_linear_breakpoint_interp_unit_defines.svh"

module piecewise_linear_breakpoint_interp_unit
  import plic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // entry_index, entry_position, phi_value, psi_value, kick_value,
  // whack_value, residue, channel, zero pad
  input  logic [167:0]     s_axis_tdata_i,
  // op
  input  logic [0:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // result_value
  output logic [31:0]      m_axis_tdata_o,
  // degenerate, saturated
  output logic [1:0]       m_axis_tuser_o
);

  localparam int IDX_LSB = 0;
  localparam int POS_LSB = IDX_LSB + IDX_W;
  localparam int VAL_LSB = POS_LSB + POS_W;
  localparam int RES_LSB = VAL_LSB + NUM_CH * VAL_W;
  localparam int CH_LSB  = RES_LSB + POS_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [CELL_IDX_W-1:0] last_idx;
  logic             in_acc, is_query, out_load;
  logic             wr_item_q;
  arith_res_t       hold_q, ares;
  logic             adone;
  logic             m_vld_q;
  logic [VAL_W-1:0] m_data_q;
  logic [1:0]       m_user_q;

  wr_t              wr;
  tok_t             tok_w [MAX_POINTS+1];
  logic [POS_W-1:0] pos_w [MAX_POINTS+1];
  chval_t           val_w [MAX_POINTS+1];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_query        = (op_e'(s_axis_tuser_i[0]) == OP_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (count_q < CNT_W'(2)) begin
      last_idx = '0;
    end else if (count_q > CNT_W'(MAX_POINTS)) begin
      last_idx = CELL_IDX_W'(MAX_POINTS - 2);
    end else begin
      last_idx = CELL_IDX_W'(count_q - CNT_W'(2));
    end
  end

  always_comb begin
    wr.en  = in_acc && !is_query;
    wr.idx = s_axis_tdata_i[POS_LSB-1:IDX_LSB];
    wr.pos = s_axis_tdata_i[VAL_LSB-1:POS_LSB];
    wr.val = s_axis_tdata_i[RES_LSB-1:VAL_LSB];
  end

  always_comb begin
    tok_w[0]     = '0;
    tok_w[0].vld = in_acc && is_query;
    tok_w[0].res = s_axis_tdata_i[CH_LSB-1:RES_LSB];
    tok_w[0].ch  = s_axis_tdata_i[CH_LSB+CH_W-1:CH_LSB];
  end

  assign pos_w[MAX_POINTS] = '0;
  assign val_w[MAX_POINTS] = '0;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    plic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_IDX_W'(g)),
      .last_idx_i (last_idx),
      .wr_i       (wr),
      .nxt_pos_i  (pos_w[g+1]),
      .nxt_val_i  (val_w[g+1]),
      .pos_o      (pos_w[g]),
      .val_o      (val_w[g]),
      .tok_i      (tok_w[g]),
      .tok_o      (tok_w[g+1])
    );
  end

  plic_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tok_w[MAX_POINTS].vld),
    .seg_i   (tok_w[MAX_POINTS]),
    .done_o  (adone),
    .res_o   (ares)
  );

  assign out_load = (state_q == ST_DONE) && (!m_vld_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = is_query ? ST_SEARCH : ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (tok_w[MAX_POINTS].vld) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (adone) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_item_q <= !is_query;
    end
    if ((state_q == ST_CALC) && adone) begin
      hold_q <= ares;
    end
    if (out_load) begin
      m_data_q <= wr_item_q ? '0 : hold_q.value;
      m_user_q <= wr_item_q ? 2'b00 : {hold_q.sat, hold_q.degen};
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  `PLIC_ASSERT_IMP(a_tail_found, clk_i, rst_ni, tok_w[MAX_POINTS].vld, tok_w[MAX_POINTS].found)
  `PLIC_ASSERT_IMP(a_tail_in_search, clk_i, rst_ni, tok_w[MAX_POINTS].vld, state_q == ST_SEARCH)
  `PLIC_ASSERT_IMP(a_done_in_calc, clk_i, rst_ni, adone, state_q == ST_CALC)
  `PLIC_ASSERT_IMP(a_rise_from_done, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(state_q == ST_DONE))
  `PLIC_ASSERT_NXT(a_write_to_done, clk_i, rst_ni, in_acc && !is_query, state_q == ST_DONE)

endmodule

`default_nettype wire
